// ===== src/assert_macros.svh =====
// Assertion macros shared by the modules that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error(MSG);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

// ===== src/pidaw_pkg.sv =====
// Shared types and constants of the anti-windup PID controller.
`timescale 1ns / 1ps

package pidaw_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_MODE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN_TS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_ALPHA   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TRACK_GAIN    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_MIN       = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_MAX       = 3'd7;

    // Anti-windup codes in control_mode[1:0]; the unused code acts as none.
    localparam logic [1:0] AW_NONE     = 2'd0;
    localparam logic [1:0] AW_BACKCALC = 2'd1;
    localparam logic [1:0] AW_CLAMP    = 2'd2;

    localparam int MODE_ON_MEAS_BIT = 2;
    localparam int MODE_REVERSE_BIT = 3;

    localparam logic signed [31:0] OUT_MIN_RESET = 32'shFFFF_0000;
    localparam logic signed [31:0] OUT_MAX_RESET = 32'sh0001_0000;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] prop_gain;
        logic signed [31:0] integ_gain_ts;
        logic signed [31:0] deriv_gain;
        logic [15:0]        deriv_alpha;
        logic [30:0]        track_gain;
        logic signed [31:0] out_min;
        logic signed [31:0] out_max;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] integrator;
        logic signed [31:0] deriv_filt;
        logic signed [31:0] last_err;
        logic signed [31:0] last_meas;
        logic signed [31:0] last_clamped;
        logic signed [31:0] last_unclamped;
    } state_t;

endpackage

// ===== src/pidaw_cfg.sv =====
// Configuration register file of the anti-windup PID controller.
`timescale 1ns / 1ps

module pidaw_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [pidaw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pidaw_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pidaw_pkg::cfg_t                    cfg
);

    pidaw_pkg::cfg_t cfg_reg;
    pidaw_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                pidaw_pkg::REG_CONTROL_MODE:  cfg_next.mode          = cfg_data[3:0];
                pidaw_pkg::REG_PROP_GAIN:     cfg_next.prop_gain     = cfg_data;
                pidaw_pkg::REG_INTEG_GAIN_TS: cfg_next.integ_gain_ts = cfg_data;
                pidaw_pkg::REG_DERIV_GAIN:    cfg_next.deriv_gain    = cfg_data;
                pidaw_pkg::REG_DERIV_ALPHA:   cfg_next.deriv_alpha   = cfg_data[15:0];
                pidaw_pkg::REG_TRACK_GAIN:    cfg_next.track_gain    = cfg_data[30:0];
                pidaw_pkg::REG_OUT_MIN:       cfg_next.out_min       = cfg_data;
                pidaw_pkg::REG_OUT_MAX:       cfg_next.out_max       = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= '0;
            cfg_reg.prop_gain     <= '0;
            cfg_reg.integ_gain_ts <= '0;
            cfg_reg.deriv_gain    <= '0;
            cfg_reg.deriv_alpha   <= '0;
            cfg_reg.track_gain    <= '0;
            cfg_reg.out_min       <= pidaw_pkg::OUT_MIN_RESET;
            cfg_reg.out_max       <= pidaw_pkg::OUT_MAX_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/pidaw_datapath.sv =====
// One-pass PID arithmetic: error, three terms, anti-windup, sum and output clamp.
`timescale 1ns / 1ps

module pidaw_datapath (
    input  pidaw_pkg::cfg_t     cfg,
    input  pidaw_pkg::state_t   st,
    input  logic signed [31:0]  setpoint,
    input  logic signed [31:0]  measurement,
    output pidaw_pkg::state_t   st_next,
    output logic signed [31:0]  control_out,
    output logic                limited
);

    // Round a Q32.32 product to Q16.16, half up: add one half, keep the floor.
    function automatic logic signed [48:0] rnd_wide(input logic signed [64:0] p);
        logic signed [64:0] s;
        s = p + 65'sd32768;
        return s[64:16];
    endfunction

    function automatic logic signed [32:0] rnd_narrow(input logic signed [48:0] p);
        logic signed [48:0] s;
        s = p + 49'sd32768;
        return s[48:16];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v[51:31] == '0 || v[51:31] == '1)
            r = v[31:0];
        else if (v[51])
            r = 32'sh8000_0000;
        else
            r = 32'sh7FFF_FFFF;
        return r;
    endfunction

    logic signed [32:0] diff;
    logic signed [32:0] diff_dir;
    logic signed [31:0] err;
    logic signed [32:0] track_diff;
    logic signed [32:0] d_in;
    logic signed [64:0] p_prod;
    logic signed [64:0] i_prod;
    logic signed [64:0] t_prod;
    logic signed [64:0] k_prod;
    logic signed [48:0] a_prod;
    logic signed [48:0] p_term;
    logic signed [48:0] i_term;
    logic signed [48:0] t_term;
    logic signed [48:0] k_term;
    logic signed [32:0] a_term;
    logic signed [51:0] integ_plain;
    logic signed [51:0] integ_track;
    logic signed [51:0] deriv_acc;
    logic signed [51:0] sum_acc;
    logic signed [31:0] integ_new;
    logic signed [31:0] deriv_new;
    logic signed [31:0] sum_sat;
    logic signed [31:0] clamped;
    logic               hold_hi;
    logic               hold_lo;
    logic               on_meas;
    logic               reverse;

    assign on_meas = cfg.mode[pidaw_pkg::MODE_ON_MEAS_BIT];
    assign reverse = cfg.mode[pidaw_pkg::MODE_REVERSE_BIT];

    assign diff     = 33'(setpoint) - 33'(measurement);
    assign diff_dir = reverse ? -diff : diff;
    assign err      = sat32(52'(diff_dir));

    // The proportional term always uses the raw difference, not the signed error.
    assign p_prod = cfg.prop_gain * diff;
    assign i_prod = cfg.integ_gain_ts * err;

    assign track_diff = 33'(st.last_clamped) - 33'(st.last_unclamped);
    assign t_prod     = $signed({1'b0, cfg.track_gain}) * track_diff;

    assign d_in   = on_meas ? (33'(st.last_meas) - 33'(measurement))
                            : (33'(err) - 33'(st.last_err));
    assign k_prod = cfg.deriv_gain * d_in;
    assign a_prod = $signed({1'b0, cfg.deriv_alpha}) * st.deriv_filt;

    assign p_term = rnd_wide(p_prod);
    assign i_term = rnd_wide(i_prod);
    assign t_term = rnd_wide(t_prod);
    assign k_term = rnd_wide(k_prod);
    assign a_term = rnd_narrow(a_prod);

    assign integ_plain = 52'(st.integrator) + 52'(i_term);
    assign integ_track = integ_plain + 52'(t_term);

    // Conditional integration stops the integrator while the last output sat
    // on a limit and the error would push it further in.
    assign hold_hi = (st.last_clamped >= cfg.out_max) && !err[31] && (err != 32'sd0);
    assign hold_lo = (st.last_clamped <= cfg.out_min) && err[31];

    always_comb
    begin
        unique case (cfg.mode[1:0])
            pidaw_pkg::AW_BACKCALC: integ_new = sat32(integ_track);
            pidaw_pkg::AW_CLAMP:    integ_new = (hold_hi || hold_lo) ? st.integrator
                                                                     : sat32(integ_plain);
            default:                integ_new = sat32(integ_plain);
        endcase
    end

    assign deriv_acc = 52'(a_term) + 52'(k_term);
    assign deriv_new = sat32(deriv_acc);

    assign sum_acc = 52'(p_term) + 52'(integ_new) + 52'(deriv_new);
    assign sum_sat = sat32(sum_acc);

    // With crossed limits the lower one is applied last and wins.
    always_comb
    begin
        clamped = sum_sat;
        if (sum_sat > cfg.out_max)
            clamped = cfg.out_max;
        if (clamped < cfg.out_min)
            clamped = cfg.out_min;
    end

    assign control_out = clamped;
    assign limited     = (clamped != sum_sat);

    always_comb
    begin
        st_next.integrator     = integ_new;
        st_next.deriv_filt     = deriv_new;
        st_next.last_err       = err;
        st_next.last_meas      = measurement;
        st_next.last_clamped   = clamped;
        st_next.last_unclamped = sum_sat;
    end

endmodule

// ===== src/pid_controller_antiwindup_top.sv =====
// Top level of the anti-windup PID controller: handshakes, state and result registers.
// Usage:
// - Samples (setpoint, measurement, Q16.16) arrive on the sample channel with
//   sample_valid / sample_ready; one result (control_out, limited) leaves on
//   the result channel with result_valid / result_ready for every sample.
// - A sample is captured in an input register, the whole PID update is done
//   in one combinational pass, and the result lands in an output register.
// - Throughput: one sample per cycle while the receiver does not stall, as the loop
//   through the integrator and derivative-filter state registers is one combinational pass.
// - When the receiver stalls, the held result and one captured sample wait;
//   sample_ready drops only when both registers are full.
// - Controller state advances only when a sample moves into the output register.
// - Configuration is a plain write port (cfg_write, cfg_index, cfg_data) and
//   should be written only while no transaction is in flight.
// - Reset (rst_n low, asynchronous) clears the controller state and both
//   valid flags and loads the register defaults: limits of -1.0 and +1.0.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pid_controller_antiwindup_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  logic signed [31:0]                setpoint,
    input  logic signed [31:0]                measurement,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic signed [31:0]                control_out,
    output logic                              limited,
    input  logic                              cfg_write,
    input  logic [pidaw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pidaw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    pidaw_pkg::cfg_t   cfg;
    pidaw_pkg::state_t state_reg;
    pidaw_pkg::state_t state_next;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic signed [31:0] setpoint_reg;
    logic signed [31:0] measurement_reg;
    logic               result_valid_reg;
    logic               result_valid_next;
    logic signed [31:0] control_out_reg;
    logic               limited_reg;
    logic signed [31:0] dp_control_out;
    logic               dp_limited;
    logic               s1_advance;
    logic               sample_take;

    pidaw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pidaw_datapath u_datapath (
        .cfg         (cfg),
        .st          (state_reg),
        .setpoint    (setpoint_reg),
        .measurement (measurement_reg),
        .st_next     (state_next),
        .control_out (dp_control_out),
        .limited     (dp_limited)
    );

    assign s1_advance   = s1_valid_reg && (!result_valid_reg || result_ready);
    assign sample_ready = !s1_valid_reg || s1_advance;
    assign sample_take  = sample_valid && sample_ready;

    assign s1_valid_next     = sample_take || (s1_valid_reg && !s1_advance);
    assign result_valid_next = s1_advance || (result_valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            if (s1_advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            setpoint_reg    <= setpoint;
            measurement_reg <= measurement;
        end
        if (s1_advance)
        begin
            control_out_reg <= dp_control_out;
            limited_reg     <= dp_limited;
        end
    end

    assign result_valid = result_valid_reg;
    assign control_out  = control_out_reg;
    assign limited      = limited_reg;

    `ASSERT_NEXT(a_state_hold, clk, rst_n, !s1_advance, state_reg == $past(state_reg),
        "controller state changed without a sample moving to the output")

    `ASSERT_IMPLY(a_ready_full, clk, rst_n, !sample_ready, s1_valid_reg && result_valid_reg,
        "sample_ready low while a register is free")

    `ASSERT_IMPLY(a_limited_value, clk, rst_n, result_valid_reg && limited_reg,
        control_out_reg == cfg.out_max || control_out_reg == cfg.out_min,
        "limited result is not on an output limit")

    `ASSERT_IMPLY(a_in_range, clk, rst_n, result_valid_reg && (cfg.out_min <= cfg.out_max),
        control_out_reg >= cfg.out_min && control_out_reg <= cfg.out_max,
        "result outside the output limits")

endmodule

// ===== tb/tb_pid_controller_antiwindup_top.sv =====
// Self-checking testbench that runs the anti-windup PID controller against a bit-exact predictor.
`timescale 1ns / 1ps

module tb_pid_controller_antiwindup_top;

    typedef logic signed [95:0] acc_t;

    typedef struct {
        logic signed [31:0] drive;
        logic               lim;
    } drive_t;

    // The fourth anti-windup code has no package name; the block treats it as none.
    localparam logic [1:0]  AW_SPARE  = 2'd3;
    localparam int          Q_ONE     = 65536;
    localparam logic [31:0] INT_MAX32 = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_MIN32 = 32'h8000_0000;
    localparam acc_t        ACC_MAX32 = 96'sh7FFF_FFFF;
    localparam acc_t        ACC_MIN32 = -ACC_MAX32 - 1;

    logic                              clk;
    logic                              rst_n;
    logic                              sample_valid;
    logic                              sample_ready;
    logic signed [31:0]                setpoint;
    logic signed [31:0]                measurement;
    logic                              result_valid;
    logic                              result_ready;
    logic signed [31:0]                control_out;
    logic                              limited;
    logic                              cfg_write;
    logic [pidaw_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [pidaw_pkg::CFG_DATA_W-1:0]  cfg_data;

    // Mirror of the register file and of the controller state.
    logic [3:0] mode_cfg;
    acc_t kp_cfg, ki_cfg, kd_cfg, alpha_cfg, trk_cfg, lo_cfg, hi_cfg;
    acc_t integ_st, dfilt_st, prev_err_st, prev_meas_st, prev_clamp_st, prev_sum_st;

    drive_t expected_drives[$];
    int     idle_pct = 29;
    int     mismatch_count = 0;
    int     samples_sent = 0;
    int     drives_checked = 0;
    int     reg_writes = 0;

    pid_controller_antiwindup_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .setpoint     (setpoint),
        .measurement  (measurement),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .control_out  (control_out),
        .limited      (limited),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_pid_controller_antiwindup_top: FAIL");
        $finish;
    end

    task automatic log_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Q16.16 product, rounded half up.
    function automatic acc_t q16_mul(input acc_t a, input acc_t b);
        return (a * b + 32768) >>> 16;
    endfunction

    function automatic acc_t clip32(input acc_t v);
        if (v > ACC_MAX32)
            return ACC_MAX32;
        if (v < ACC_MIN32)
            return ACC_MIN32;
        return v;
    endfunction

    function automatic logic [31:0] mode_word(input logic [1:0] aw, input logic on_meas,
                                              input logic rev);
        logic [31:0] w;
        w = '0;
        w[1:0] = aw;
        w[pidaw_pkg::MODE_ON_MEAS_BIT] = on_meas;
        w[pidaw_pkg::MODE_REVERSE_BIT] = rev;
        return w;
    endfunction

    task automatic reset_mirror();
        mode_cfg = '0;
        kp_cfg = 0;
        ki_cfg = 0;
        kd_cfg = 0;
        alpha_cfg = 0;
        trk_cfg = 0;
        lo_cfg = pidaw_pkg::OUT_MIN_RESET;
        hi_cfg = pidaw_pkg::OUT_MAX_RESET;
        integ_st = 0;
        dfilt_st = 0;
        prev_err_st = 0;
        prev_meas_st = 0;
        prev_clamp_st = 0;
        prev_sum_st = 0;
    endtask

    // One controller update: returns the drive value and the limit flag.
    task automatic advance_pid(input logic signed [31:0] sp_in, input logic signed [31:0] ms_in,
                               output drive_t res);
        acc_t sp, ms, diff, err, p_term, d, sum, u;
        logic [1:0] aw;
        logic hold;
        sp = sp_in;
        ms = ms_in;
        aw = mode_cfg[1:0];
        diff = sp - ms;
        err = clip32(mode_cfg[pidaw_pkg::MODE_REVERSE_BIT] ? -diff : diff);
        p_term = q16_mul(kp_cfg, diff);
        if (aw == pidaw_pkg::AW_BACKCALC)
        begin
            integ_st = clip32(integ_st + q16_mul(ki_cfg, err)
                              + q16_mul(trk_cfg, prev_clamp_st - prev_sum_st));
        end
        else if (aw == pidaw_pkg::AW_CLAMP)
        begin
            hold = (prev_clamp_st >= hi_cfg && err > 0) || (prev_clamp_st <= lo_cfg && err < 0);
            if (!hold)
                integ_st = clip32(integ_st + q16_mul(ki_cfg, err));
        end
        else
        begin
            integ_st = clip32(integ_st + q16_mul(ki_cfg, err));
        end
        d = mode_cfg[pidaw_pkg::MODE_ON_MEAS_BIT] ? prev_meas_st - ms : err - prev_err_st;
        dfilt_st = clip32(q16_mul(alpha_cfg, dfilt_st) + q16_mul(kd_cfg, d));
        sum = clip32(p_term + integ_st + dfilt_st);
        u = sum;
        if (u > hi_cfg)
            u = hi_cfg;
        if (u < lo_cfg)
            u = lo_cfg;
        prev_err_st = err;
        prev_meas_st = ms;
        prev_sum_st = sum;
        prev_clamp_st = u;
        res.drive = u[31:0];
        res.lim = (u != sum);
    endtask

    task automatic send_sample(input logic signed [31:0] sp, input logic signed [31:0] ms);
        drive_t res;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        setpoint <= sp;
        measurement <= ms;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        advance_pid(sp, ms, res);
        expected_drives.push_back(res);
        samples_sent++;
    endtask

    task automatic drain_results();
        sample_valid <= 1'b0;
        while (expected_drives.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [pidaw_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            pidaw_pkg::REG_CONTROL_MODE:  mode_cfg = value[3:0];
            pidaw_pkg::REG_PROP_GAIN:     kp_cfg = $signed(value);
            pidaw_pkg::REG_INTEG_GAIN_TS: ki_cfg = $signed(value);
            pidaw_pkg::REG_DERIV_GAIN:    kd_cfg = $signed(value);
            pidaw_pkg::REG_DERIV_ALPHA:   alpha_cfg = value[15:0];
            pidaw_pkg::REG_TRACK_GAIN:    trk_cfg = value[30:0];
            pidaw_pkg::REG_OUT_MIN:       lo_cfg = $signed(value);
            pidaw_pkg::REG_OUT_MAX:       hi_cfg = $signed(value);
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    // Waits for the block to go idle, then rewrites the whole register file.
    task automatic load_tuning(input logic [31:0] mode, input logic [31:0] kp,
                               input logic [31:0] ki, input logic [31:0] kd,
                               input logic [31:0] alpha, input logic [31:0] trk,
                               input logic [31:0] lo, input logic [31:0] hi);
        drain_results();
        write_reg(pidaw_pkg::REG_CONTROL_MODE, mode);
        write_reg(pidaw_pkg::REG_PROP_GAIN, kp);
        write_reg(pidaw_pkg::REG_INTEG_GAIN_TS, ki);
        write_reg(pidaw_pkg::REG_DERIV_GAIN, kd);
        write_reg(pidaw_pkg::REG_DERIV_ALPHA, alpha);
        write_reg(pidaw_pkg::REG_TRACK_GAIN, trk);
        write_reg(pidaw_pkg::REG_OUT_MIN, lo);
        write_reg(pidaw_pkg::REG_OUT_MAX, hi);
    endtask

    function automatic logic [31:0] pick_gain(input int span);
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = INT_MAX32;
            2: v = INT_MIN32;
            3: v = $urandom;
            default:
            begin
                v = $urandom_range(0, span);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic randomize_tuning(input logic [1:0] aw);
        logic [31:0] mode, alpha, trk, lo, hi;
        int k, c;
        mode = $urandom;
        mode[1:0] = aw;
        case ($urandom_range(0, 3))
            0: alpha = '0;
            1: alpha = 32'h0000_FFFF;
            default: alpha = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0: trk = '0;
            1: trk = 32'hFFFF_FFFF;
            2: trk = $urandom;
            default: trk = $urandom_range(0, 2 * Q_ONE);
        endcase
        k = $urandom_range(Q_ONE / 2, 20 * Q_ONE);
        case ($urandom_range(0, 5))
            0:
            begin
                lo = INT_MIN32;
                hi = INT_MAX32;
            end
            1:
            begin
                lo = $urandom;
                hi = $urandom;
            end
            2:
            begin
                lo = k;
                hi = -k;
            end
            default:
            begin
                c = int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
                lo = c - k;
                hi = c + k;
            end
        endcase
        load_tuning(mode, pick_gain(4 * Q_ONE), pick_gain(Q_ONE / 2), pick_gain(2 * Q_ONE),
                    alpha, trk, lo, hi);
    endtask

    function automatic logic signed [31:0] random_level();
        return int'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
    endfunction

    // A plant that drifts toward a setpoint that jumps now and then, mixed with raw noise.
    task automatic run_closed_loop(input int n);
        logic signed [31:0] target, plant;
        int i, noise;
        target = random_level();
        plant = random_level();
        for (i = 0; i < n; i++)
        begin
            if (i == n / 2)
                drain_results();
            if ($urandom_range(0, 11) == 0)
                target = random_level();
            noise = int'($urandom_range(0, 2048)) - 1024;
            plant = plant + ((target - plant) >>> $urandom_range(1, 3)) + noise;
            if ($urandom_range(0, 4) == 0)
                send_sample($urandom, $urandom);
            else
                send_sample(target, plant);
        end
    endtask

    task automatic test_after_reset();
        send_sample(INT_MAX32, INT_MIN32);
        send_sample(0, 0);
    endtask

    task automatic test_error_extremes();
        load_tuning(mode_word(pidaw_pkg::AW_NONE, 1'b0, 1'b0), INT_MAX32, Q_ONE, 0, 0, 0,
                    INT_MIN32, INT_MAX32);
        send_sample(INT_MAX32, INT_MIN32);
        send_sample(INT_MIN32, INT_MAX32);
        load_tuning(mode_word(pidaw_pkg::AW_NONE, 1'b0, 1'b1), INT_MIN32, Q_ONE, 0, 0, 0,
                    INT_MIN32, INT_MAX32);
        send_sample(INT_MAX32, INT_MIN32);
        send_sample(INT_MIN32, INT_MAX32);
        send_sample(0, 0);
    endtask

    task automatic test_antiwindup_modes();
        load_tuning(mode_word(pidaw_pkg::AW_NONE, 1'b0, 1'b0), Q_ONE, Q_ONE / 2, 0, 0, 0,
                    -Q_ONE, Q_ONE);
        send_sample(4 * Q_ONE, 0);
        send_sample(4 * Q_ONE, 0);
        // Bit 31 of the tracking gain is dropped by the register.
        load_tuning(mode_word(pidaw_pkg::AW_BACKCALC, 1'b0, 1'b0), Q_ONE, Q_ONE / 2, 0, 0,
                    32'hFFFF_FFFF, -Q_ONE, Q_ONE);
        send_sample(4 * Q_ONE, 0);
        send_sample(-4 * Q_ONE, 0);
        // Saturate high, hold; then saturate low, hold.
        load_tuning(mode_word(pidaw_pkg::AW_CLAMP, 1'b0, 1'b0), Q_ONE, Q_ONE / 2, 0, 0, 0,
                    -Q_ONE, Q_ONE);
        send_sample(4 * Q_ONE, 0);
        send_sample(4 * Q_ONE, 0);
        send_sample(-4 * Q_ONE, 0);
        send_sample(-4 * Q_ONE, 0);
        load_tuning(mode_word(AW_SPARE, 1'b1, 1'b1), Q_ONE, Q_ONE / 2, Q_ONE, Q_ONE / 2, Q_ONE,
                    -Q_ONE, Q_ONE);
        send_sample(4 * Q_ONE, 0);
        send_sample(0, 2 * Q_ONE);
    endtask

    task automatic test_derivative_paths();
        load_tuning(mode_word(pidaw_pkg::AW_NONE, 1'b1, 1'b0), 0, 0, INT_MAX32, 32'h0000_FFFF,
                    0, INT_MIN32, INT_MAX32);
        send_sample(0, INT_MAX32);
        send_sample(0, INT_MIN32);
        load_tuning(mode_word(pidaw_pkg::AW_NONE, 1'b0, 1'b1), 0, 0, INT_MIN32, 32'h0000_FFFF,
                    0, INT_MIN32, INT_MAX32);
        send_sample(INT_MAX32, INT_MIN32);
        // Zero gain and zero pole switch the derivative off.
        load_tuning(mode_word(pidaw_pkg::AW_NONE, 1'b0, 1'b0), 0, 0, 0, 0, 0,
                    INT_MIN32, INT_MAX32);
        send_sample(Q_ONE, 0);
    endtask

    task automatic test_crossed_limits();
        // With the lower limit above the upper one, the lower limit wins.
        load_tuning(mode_word(pidaw_pkg::AW_CLAMP, 1'b0, 1'b0), Q_ONE, Q_ONE / 4, 0, 0, 0,
                    2 * Q_ONE, -2 * Q_ONE);
        send_sample(0, 0);
        send_sample(10 * Q_ONE, 0);
        send_sample(-10 * Q_ONE, 0);
    endtask

    task automatic test_random_tuning(input int phases, input int per_phase);
        int k;
        for (k = 0; k < phases; k++)
        begin
            randomize_tuning(k[1:0]);
            run_closed_loop(per_phase);
        end
    endtask

    task automatic test_back_to_back(input int n);
        idle_pct = 0;
        randomize_tuning(2'($urandom_range(0, 3)));
        run_closed_loop(n);
        idle_pct = 29;
    endtask

    // Result side: random back-pressure and comparison against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        drive_t want;
        result_ready <= rst_n && ($urandom_range(0, 99) >= idle_pct);
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_drives.size() == 0)
            begin
                log_mismatch($sformatf("unexpected transaction, control_out %08h", control_out));
            end
            else
            begin
                want = expected_drives.pop_front();
                drives_checked++;
                if (control_out !== want.drive)
                    log_mismatch($sformatf("control_out %08h, expected %08h",
                                           control_out, want.drive));
                if (limited !== want.lim)
                    log_mismatch($sformatf("limited %0b, expected %0b", limited, want.lim));
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        sample_valid <= 1'b0;
        setpoint <= '0;
        measurement <= '0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        reset_mirror();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_error_extremes();
        test_antiwindup_modes();
        test_derivative_paths();
        test_crossed_limits();
        test_random_tuning(9, 52);
        test_back_to_back(80);

        drain_results();
        repeat (4) @(posedge clk);
        $display("Sent %0d samples across %0d register writes and compared %0d drive values.",
                 samples_sent, reg_writes, drives_checked);
        $display("Covered every anti-windup code, both derivative sources, reverse action, "
                 , "crossed and extreme limits, with and without back-pressure.");
        if (mismatch_count == 0)
            $display("tb_pid_controller_antiwindup_top: PASS");
        else
            $display("tb_pid_controller_antiwindup_top: FAIL");
        $finish;
    end

endmodule
